// ===== design/msxl_pkg.sv =====
// Shared types, constants and lookup tables of the masked softmax cross-entropy core.
package msxl_pkg;

    // Largest supported vector length and the width of a count that can hold it.
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int CNT_W            = 7;
    localparam int QUEUE_DEPTH      = 2;

    // One classified transaction passed from the front end to the back end.
    typedef struct packed {
        logic                    wr;       // element is stored
        logic [CNT_W-1:0]        idx;      // store address
        logic signed [15:0]      logit;
        logic [15:0]             target;
        logic                    masked;
        logic                    last;     // closes the run
        logic [CNT_W-1:0]        count;    // stored elements, valid with last
        logic signed [15:0]      run_max;  // maximum unmasked logit, valid with last
        logic                    dropped;  // elements were dropped, valid with last
    } t_entry;

    // 2^-x over sixteenths, Q1.15.
    localparam logic [15:0] POW2_TAB [17] = '{
        16'd32768, 16'd31379, 16'd30048, 16'd28774, 16'd27554, 16'd26386,
        16'd25268, 16'd24196, 16'd23170, 16'd22188, 16'd21247, 16'd20347,
        16'd19484, 16'd18658, 16'd17867, 16'd17109, 16'd16384
    };

    // log2(1 + x) over sixteenths, Q16.
    localparam logic [16:0] LOG2_TAB [17] = '{
        17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
        17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
        17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
    };

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [15:0] ONE_Q15   = 16'd32768;

endpackage

// ===== design/msxl_front.sv =====
// Front end: accepts elements, classifies them against capacity and tracks the run maximum.
module msxl_front
    import msxl_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_logit,
    input  logic [15:0]        i_target,
    input  logic               i_masked,
    input  logic               i_last_in,
    input  logic               i_full,
    output logic               o_push,
    output t_entry             o_entry
);

    logic [CNT_W-1:0]   r_count;
    logic signed [15:0] r_max;
    logic               r_dropped;
    logic [CNT_W-1:0]   n_count;
    logic signed [15:0] n_max;
    logic               n_dropped;
    logic               stored;

    assign busy   = i_full;
    assign o_push = start && !i_full;
    assign stored = (r_count < CNT_W'(MAX_ELEMENTS));

    // Classify the element and work out the run state it leaves behind.
    always_comb begin
        n_count   = stored ? r_count + CNT_W'(1) : r_count;
        n_max     = (stored && !i_masked && (i_logit > r_max)) ? i_logit : r_max;
        n_dropped = r_dropped || !stored;

        o_entry.wr      = stored;
        o_entry.idx     = r_count;
        o_entry.logit   = i_logit;
        o_entry.target  = i_target;
        o_entry.masked  = i_masked;
        o_entry.last    = i_last_in;
        o_entry.count   = n_count;
        o_entry.run_max = n_max;
        o_entry.dropped = n_dropped;
    end

    // Run state returns to its reset value once the run is closed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_max     <= 16'sh8000;
            r_dropped <= 1'b0;
        end else if (o_push) begin
            if (i_last_in) begin
                r_count   <= '0;
                r_max     <= 16'sh8000;
                r_dropped <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_max     <= n_max;
                r_dropped <= n_dropped;
            end
        end
    end

endmodule

// ===== design/msxl_queue.sv =====
// Short queue of classified transactions between the front and back ends.
module msxl_queue
    import msxl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_empty,
    input  logic   i_pop,
    output t_entry o_entry
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_entry          r_slot [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_fill;

    assign o_full  = (r_fill == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_entry = r_slot[r_rp];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (i_pop)  r_rp <= r_rp + PW'(1);
            if (i_push && !i_pop)      r_fill <= r_fill + (PW+1)'(1);
            else if (!i_push && i_pop) r_fill <= r_fill - (PW+1)'(1);
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_entry;
    end

endmodule

// ===== design/msxl_back.sv =====
// Back end: element stores, exp pass, reciprocal divider and normalise/loss pass.
module msxl_back
    import msxl_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    output logic               o_pop,
    input  t_entry             i_entry,
    output logic               o_valid,
    output logic [15:0]        o_prob,
    output logic signed [16:0] o_grad,
    output logic [31:0]        o_loss,
    output logic               o_overflow,
    output logic               o_last_out
);

    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_E0, S_E1, S_E2, S_E3, S_DIV,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_idx;
    logic signed [15:0] r_max;
    logic               r_drop;
    logic [21:0]        r_sum;
    logic [31:0]        r_inv;
    logic [21:0]        r_rem;
    logic [4:0]         r_dcnt;
    logic [31:0]        r_loss;

    // Element stores.
    logic [15:0] r_logit_mem  [MAX_ELEMENTS];
    logic [15:0] r_target_mem [MAX_ELEMENTS];
    logic        r_mask_mem   [MAX_ELEMENTS];
    logic [15:0] r_exp_mem    [MAX_ELEMENTS];
    logic [15:0] r_rd_logit;
    logic [15:0] r_rd_target;
    logic        r_rd_mask;
    logic [15:0] r_rd_exp;

    // Datapath registers.
    logic [32:0] r_y;
    logic [6:0]  r_ip;
    logic [15:0] r_a;
    logic [27:0] r_prod;
    logic [47:0] r_pp;
    logic [15:0] r_t;
    logic [15:0] r_p;
    logic signed [16:0] r_g;
    logic        r_act;
    logic [3:0]  r_b;
    logic [16:0] r_l0;
    logic [27:0] r_lprod;
    logic [36:0] r_nlp;
    logic [37:0] r_tp;

    // Output registers.
    logic               r_valid;
    logic [15:0]        r_prob;
    logic signed [16:0] r_grad;
    logic [31:0]        r_oloss;
    logic               r_ovf;
    logic               r_lastout;

    logic               last_elem;
    logic signed [16:0] d17;
    logic [15:0]        d;
    logic [15:0]        fr;
    logic [15:0]        tab_a;
    logic [15:0]        tab_b;
    logic [15:0]        v;
    logic [16:0]        vr;
    logic [15:0]        e;
    logic [22:0]        rem_sh;
    logic [32:0]        ppr;
    logic [15:0]        p;
    logic [15:0]        pc;
    logic [3:0]         b;
    logic [15:0]        m;
    logic [15:0]        f;
    logic [16:0]        lg_a;
    logic [16:0]        lg_b;
    logic [16:0]        lsum;
    logic [20:0]        base;
    logic [20:0]        nl2;
    logic [20:0]        nlog;
    logic [22:0]        term;
    logic [32:0]        acc;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign last_elem = (r_idx + CNT_W'(1) == r_n);

    // Exp pass arithmetic.
    always_comb begin
        d17   = $signed({r_max[15], r_max}) - $signed({r_rd_logit[15], r_rd_logit});
        d     = (r_rd_mask || d17[16]) ? 16'd0 : d17[15:0];
        fr    = r_y[25:10];
        tab_a = POW2_TAB[{1'b0, fr[15:12]}];
        tab_b = POW2_TAB[{1'b0, fr[15:12]} + 5'd1];
        v     = r_a - 16'((r_prod + 28'd2048) >> 12);
        vr    = {1'b0, v} + (17'd1 << (r_ip[3:0] - 4'd1));
        if (r_rd_mask || r_ip >= 7'd16) e = 16'd0;
        else if (r_ip == 7'd0)          e = v;
        else                            e = 16'(vr >> r_ip[3:0]);
        rem_sh = {r_rem, (r_dcnt == 5'd31)};
    end

    // Normalise and log arithmetic.
    always_comb begin
        ppr = 33'((r_pp + 48'd32768) >> 16);
        if (r_rd_mask)                   p = 16'd0;
        else if (ppr > 33'(ONE_Q15))     p = ONE_Q15;
        else                             p = ppr[15:0];
        pc = (p == 16'd0) ? 16'd1 : p;
        b  = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (pc[k]) b = 4'(k);
        end
        m    = 16'(pc << (4'd15 - b));
        f    = m - ONE_Q15;
        lg_a = LOG2_TAB[{1'b0, f[14:11]}];
        lg_b = LOG2_TAB[{1'b0, f[14:11]} + 5'd1];
        lsum = r_l0 + 17'((r_lprod + 28'd1024) >> 11);
        base = 21'(4'd15 - r_b) << 16;
        nl2  = (21'(lsum) > base) ? 21'd0 : base - 21'(lsum);
        nlog = 21'((r_nlp + 37'd32768) >> 16);
        term = 23'((r_tp + 38'd16384) >> 15);
        acc  = 33'(r_loss) + 33'(term);
    end

    // Stores: loaded from the queue, exp written back during the exp pass.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.wr) begin
            r_logit_mem[i_entry.idx[IW-1:0]]  <= i_entry.logit;
            r_target_mem[i_entry.idx[IW-1:0]] <= i_entry.target;
            r_mask_mem[i_entry.idx[IW-1:0]]   <= i_entry.masked;
        end
        if (r_state == S_E3) r_exp_mem[r_idx[IW-1:0]] <= e;
        r_rd_logit  <= r_logit_mem[r_idx[IW-1:0]];
        r_rd_target <= r_target_mem[r_idx[IW-1:0]];
        r_rd_mask   <= r_mask_mem[r_idx[IW-1:0]];
        r_rd_exp    <= r_exp_mem[r_idx[IW-1:0]];
    end

    // Pipeline data registers of both passes.
    always_ff @(posedge i_clk) begin
        r_y     <= 33'(d) * 33'(LOG2E_Q16);
        r_ip    <= r_y[32:26];
        r_a     <= tab_a;
        r_prod  <= 28'(tab_a - tab_b) * 28'(fr[11:0]);
        r_pp    <= 48'(r_rd_exp) * 48'(r_inv);
        r_t     <= (r_rd_target > ONE_Q15) ? ONE_Q15 : r_rd_target;
        r_p     <= p;
        r_g     <= r_rd_mask ? 17'sd0 : $signed({1'b0, p}) - $signed({1'b0, r_t});
        r_act   <= !r_rd_mask && (r_t != 16'd0);
        r_b     <= b;
        r_l0    <= lg_a;
        r_lprod <= 28'(lg_b - lg_a) * 28'(f[10:0]);
        r_nlp   <= 37'(nl2) * 37'(LN2_Q16);
        r_tp    <= 38'(r_t) * 38'(nlog);
    end

    // Sequencer with registered result outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_n       <= '0;
            r_idx     <= '0;
            r_max     <= 16'sh8000;
            r_drop    <= 1'b0;
            r_sum     <= '0;
            r_inv     <= '0;
            r_rem     <= '0;
            r_dcnt    <= '0;
            r_loss    <= '0;
            r_valid   <= 1'b0;
            r_prob    <= '0;
            r_grad    <= '0;
            r_oloss   <= '0;
            r_ovf     <= 1'b0;
            r_lastout <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_entry.last) begin
                        r_n     <= i_entry.count;
                        r_max   <= i_entry.run_max;
                        r_drop  <= i_entry.dropped;
                        r_idx   <= '0;
                        r_sum   <= '0;
                        r_state <= S_E0;
                    end
                end
                S_E0: r_state <= S_E1;
                S_E1: r_state <= S_E2;
                S_E2: r_state <= S_E3;
                S_E3: begin
                    r_sum <= r_sum + 22'(e);
                    if (last_elem) begin
                        r_rem   <= '0;
                        r_inv   <= '0;
                        r_dcnt  <= 5'd31;
                        r_state <= S_DIV;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_E0;
                    end
                end
                S_DIV: begin
                    // One quotient bit of 2^31 / sum per cycle.
                    if (r_sum != 22'd0 && rem_sh >= 23'(r_sum)) begin
                        r_rem          <= 22'(rem_sh - 23'(r_sum));
                        r_inv[r_dcnt]  <= 1'b1;
                    end else begin
                        r_rem <= rem_sh[21:0];
                    end
                    if (r_dcnt == 5'd0) begin
                        r_idx   <= '0;
                        r_loss  <= '0;
                        r_state <= S_P0;
                    end else begin
                        r_dcnt <= r_dcnt - 5'd1;
                    end
                end
                S_P0: r_state <= S_P1;
                S_P1: r_state <= S_P2;
                S_P2: r_state <= S_P3;
                S_P3: r_state <= S_P4;
                S_P4: r_state <= S_P5;
                S_P5: begin
                    logic [31:0] nloss;
                    nloss = r_loss;
                    if (r_act) nloss = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
                    r_loss    <= nloss;
                    r_valid   <= 1'b1;
                    r_prob    <= r_p;
                    r_grad    <= r_g;
                    r_oloss   <= last_elem ? nloss : 32'd0;
                    r_ovf     <= r_drop;
                    r_lastout <= last_elem;
                    if (last_elem) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_P0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_prob     = r_prob;
    assign o_grad     = r_grad;
    assign o_loss     = r_oloss;
    assign o_overflow = r_ovf;
    assign o_last_out = r_lastout;

endmodule

// ===== design/masked_softmax_xent_loss_core.sv =====
// Top level of the masked softmax cross-entropy core.
//
//  Channel   Handshake            Payload
//  input     start & !busy        i_logit, i_target, i_masked, i_last_in
//  result    o_valid (one cycle)  o_prob, o_grad, o_loss, o_overflow, o_last_out
//
// An element is queued by the front end and written to the stores by the back end.
// After the closing element the back end runs the exp pass over every element, then
// the bit-serial reciprocal and then the normalise/loss pass over every element,
// one result per element. busy rises while the queue is full.
// Reset is synchronous; results cannot be stalled by the receiver.
module masked_softmax_xent_loss_core
    import msxl_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_logit,
    input  logic [15:0]        i_target,
    input  logic               i_masked,
    input  logic               i_last_in,
    output logic               o_valid,
    output logic [15:0]        o_prob,
    output logic signed [16:0] o_grad,
    output logic [31:0]        o_loss,
    output logic               o_overflow,
    output logic               o_last_out
);

    t_entry push_entry;
    t_entry pop_entry;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    msxl_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_logit   (i_logit),
        .i_target  (i_target),
        .i_masked  (i_masked),
        .i_last_in (i_last_in),
        .i_full    (full),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    msxl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_entry (pop_entry)
    );

    msxl_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_entry    (pop_entry),
        .o_valid    (o_valid),
        .o_prob     (o_prob),
        .o_grad     (o_grad),
        .o_loss     (o_loss),
        .o_overflow (o_overflow),
        .o_last_out (o_last_out)
    );

endmodule

// ===== dv/tb_masked_softmax_xent_loss_core.sv =====
// Self-checking testbench for the masked softmax cross-entropy loss core.
module tb_masked_softmax_xent_loss_core;
    import msxl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY  = MAX_ELEMENTS_DEF;
    localparam int END_WAIT  = 1000;
    localparam int CYCLE_CAP = 600000;

    // One element to send, with its own pacing.
    typedef struct {
        logic signed [15:0] logit;
        logic [15:0]        target;
        logic               masked;
        logic               last;
        bit                 drain;     // wait for all results before sending
        int                 gap_pct;   // chance of an idle cycle before sending
    } t_elem;

    // One expected result.
    typedef struct {
        logic [15:0]        prob;
        logic signed [16:0] grad;
        logic [31:0]        loss;
        logic               overflow;
        logic               last_out;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_logit = '0;
    logic [15:0]        i_target = '0;
    logic               i_masked = 1'b0;
    logic               i_last_in = 1'b0;
    logic               o_valid;
    logic [15:0]        o_prob;
    logic signed [16:0] o_grad;
    logic [31:0]        o_loss;
    logic               o_overflow;
    logic               o_last_out;

    t_elem   pending_elems[$];
    t_result expected_results[$];
    t_elem   cur_elem;
    int      failures = 0;
    int      cycle_count = 0;

    // Softmax state mirrored from the block.
    logic signed [15:0] sm_logit [CAPACITY];
    logic [15:0]        sm_target [CAPACITY];
    logic               sm_mask [CAPACITY];
    int                 sm_count = 0;
    int                 sm_max = -32768;
    bit                 sm_dropped = 1'b0;

    masked_softmax_xent_loss_core dut (.*);

    always #6 i_clk = ~i_clk;

    // exp(-d/1024) in Q1.15 through the power-of-two table.
    function automatic int unsigned exp_q15(int unsigned d);
        longint unsigned y;
        int unsigned ip, fr, seg, r, a, b, v;
        y   = longint'(d) * 94548;
        ip  = int'(y >> 26);
        fr  = int'((y >> 10) & 64'hFFFF);
        seg = fr >> 12;
        r   = fr & 12'hFFF;
        a   = POW2_TAB[seg];
        b   = POW2_TAB[seg + 1];
        v   = a - (((a - b) * r + 2048) >> 12);
        if (ip >= 16) return 0;
        if (ip == 0) return v;
        return (v + (1 << (ip - 1))) >> ip;
    endfunction

    // -ln(p/32768) in Q16 for p from 1 to 32768.
    function automatic longint unsigned neg_ln_q16(int unsigned p);
        int unsigned b, m, f, seg, r, lg;
        longint nl2;
        b = 0;
        while (b < 15 && (p >> (b + 1)) != 0) b++;
        m   = (p << (15 - b)) & 16'hFFFF;
        f   = (m >= 32768) ? m - 32768 : 0;
        seg = (f >> 11) & 15;
        r   = f & 11'h7FF;
        lg  = LOG2_TAB[seg] + (((LOG2_TAB[seg + 1] - LOG2_TAB[seg]) * r + 1024) >> 11);
        nl2 = (longint'(15 - b) << 16) - longint'(lg);
        if (nl2 < 0) nl2 = 0;
        return (longint'(nl2) * 45426 + 32768) >> 16;
    endfunction

    // Buffer one element and, when it closes the vector, queue its results.
    task automatic absorb_elem(t_elem el);
        int unsigned expv [CAPACITY];
        int unsigned sum, inv, t, p;
        longint unsigned pp, loss;
        int d, g;
        t_result res;
        if (sm_count < CAPACITY) begin
            sm_logit[sm_count]  = el.logit;
            sm_target[sm_count] = el.target;
            sm_mask[sm_count]   = el.masked;
            sm_count++;
            if (!el.masked && int'(el.logit) > sm_max) sm_max = el.logit;
        end else begin
            sm_dropped = 1'b1;
        end
        if (!el.last) return;
        sum = 0;
        inv = 0;
        loss = 0;
        for (int i = 0; i < sm_count; i++) begin
            expv[i] = 0;
            if (!sm_mask[i]) begin
                d = sm_max - int'(sm_logit[i]);
                if (d < 0) d = 0;
                expv[i] = exp_q15(d);
            end
            if (expv[i] > 16'hFFFF) expv[i] = 16'hFFFF;
            sum += expv[i];
        end
        if (sum > 0) inv = 32'h8000_0000 / sum;
        for (int i = 0; i < sm_count; i++) begin
            p = 0;
            g = 0;
            if (!sm_mask[i]) begin
                t  = sm_target[i];
                pp = (longint'(expv[i]) * inv + 32768) >> 16;
                if (t > 32768) t = 32768;
                p = (pp > 32768) ? 32768 : int'(pp);
                g = int'(p) - int'(t);
                if (t > 0) begin
                    loss += (longint'(t) * neg_ln_q16(p > 0 ? p : 1) + 16384) >> 15;
                    if (loss > 64'hFFFF_FFFF) loss = 64'hFFFF_FFFF;
                end
            end
            res.prob     = p[15:0];
            res.grad     = g[16:0];
            res.loss     = (i == sm_count - 1) ? loss[31:0] : 32'd0;
            res.overflow = sm_dropped;
            res.last_out = (i == sm_count - 1);
            expected_results.push_back(res);
        end
        sm_count   = 0;
        sm_max     = -32768;
        sm_dropped = 1'b0;
    endtask

    // Driver: record the accepted transaction, then present the next one.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) absorb_elem(cur_elem);
            if (pending_elems.size() > 0 &&
                $urandom_range(99) >= pending_elems[0].gap_pct &&
                !(pending_elems[0].drain && expected_results.size() != 0)) begin
                cur_elem = pending_elems.pop_front();
                i_logit   <= cur_elem.logit;
                i_target  <= cur_elem.target;
                i_masked  <= cur_elem.masked;
                i_last_in <= cur_elem.last;
                start     <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: prob %0d grad %0d", o_prob, o_grad);
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (o_prob !== want.prob) begin
                    $error("prob: expected %0d, got %0d", want.prob, o_prob);
                    failures++;
                end
                if (o_grad !== want.grad) begin
                    $error("grad: expected %0d, got %0d", want.grad, o_grad);
                    failures++;
                end
                if (o_loss !== want.loss) begin
                    $error("loss: expected %0d, got %0d", want.loss, o_loss);
                    failures++;
                end
                if (o_overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, o_overflow);
                    failures++;
                end
                if (o_last_out !== want.last_out) begin
                    $error("last_out: expected %0d, got %0d", want.last_out, o_last_out);
                    failures++;
                end
            end
        end
    end

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_elem(int lg, int tg, bit mk, bit lst, bit drn, int gap);
        t_elem el;
        el.logit   = lg[15:0];
        el.target  = tg[15:0];
        el.masked  = mk;
        el.last    = lst;
        el.drain   = drn;
        el.gap_pct = gap;
        pending_elems.push_back(el);
    endtask

    // A vector of random content; wide logits now and then, else a narrow spread.
    task automatic add_vector(int len, int gap, bit drn);
        int lg, tg;
        for (int i = 0; i < len; i++) begin
            lg = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                          : int'($urandom_range(6000)) - 3000;
            tg = ($urandom_range(9) == 0) ? int'($urandom_range(65535))
                                          : int'($urandom_range(32768));
            add_elem(lg, tg, $urandom_range(3) == 0, i == len - 1, drn && i == 0, gap);
        end
    endtask

    initial begin
        int gaps [3];
        int sent;
        int len;
        gaps = '{0, 48, 9};
        // Directed: field extremes, target above one, a masked closing element.
        add_elem(32767, 32768, 0, 0, 0, 0);
        add_elem(-32768, 0, 0, 0, 0, 0);
        add_elem(0, 65535, 0, 0, 0, 0);
        add_elem(32767, 1, 0, 0, 0, 0);
        add_elem(100, 16384, 1, 1, 0, 0);
        // Every element masked.
        add_elem(500, 32768, 1, 0, 0, 0);
        add_elem(-500, 100, 1, 1, 0, 0);
        // Single element, then two equal logits.
        add_elem(-32768, 32768, 0, 1, 0, 0);
        add_elem(1234, 16384, 0, 0, 1, 0);
        add_elem(1234, 16384, 0, 1, 0, 0);
        // Tiny probability against a full target, so the clamp at one LSB applies.
        add_elem(32767, 0, 0, 0, 0, 0);
        add_elem(-32768, 32768, 0, 1, 0, 0);
        // Random vectors through the idling phases, mostly short.
        sent = 0;
        for (int v = 0; sent < 40; v++) begin
            len = $urandom_range(1, 8);
            add_vector(len, gaps[v % 3], v % 5 == 0);
            sent += len;
        end
        // Capacity filled, then dropped elements including a dropped closer.
        add_vector(CAPACITY + 2, 9, 1);
        add_vector(3, 48, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_elems.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
